@@ src/swgl_pkg.sv @@
// shared types, constants and tables for the swiglu activation pipeline
package swgl_pkg;

    localparam int POW_STEPS    = 16;
    localparam int SEED_ENTRIES = 256;

    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [15:0] SIG_MAX = 16'hFFFF;

    // 2^(2^-(k+1)) in q1.15 for entry k, fraction bit 15 first
    localparam logic [15:0] POW2_TAB [POW_STEPS] = '{
        16'd46341, 16'd38968, 16'd35734, 16'd34219, 16'd33486, 16'd33125, 16'd32946, 16'd32857,
        16'd32812, 16'd32790, 16'd32779, 16'd32774, 16'd32771, 16'd32769, 16'd32769, 16'd32768
    };

    typedef logic [29:0] seed_tab_t [SEED_ENTRIES];

    // floor(2^39 / (2*top+1)) for top = 256..511, by long division
    function automatic seed_tab_t build_seed_tab();
        seed_tab_t   tab;
        logic [10:0] den;
        logic [10:0] rem;
        logic [39:0] quo;
        for (int i = 0; i < SEED_ENTRIES; i++) begin
            den = 11'(2 * (SEED_ENTRIES + i) + 1);
            rem = '0;
            quo = '0;
            for (int b = 39; b >= 0; b--) begin
                rem = {rem[9:0], (b == 39)};
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            tab[i] = quo[29:0];
        end
        return tab;
    endfunction

    localparam seed_tab_t SEED_TAB = build_seed_tab();

    typedef struct packed {
        logic signed [31:0] gate_value;
        logic signed [31:0] up_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] gate_value;
        logic signed [31:0] up_value;
        logic [7:0]         mant;
        logic [5:0]         shamt;
        logic               zero;
        logic               full;
    } exp_item_t;

    typedef struct packed {
        logic signed [31:0] gate_value;
        logic signed [31:0] up_value;
        logic [15:0]        sig;
    } sig_item_t;

endpackage

@@ src/swgl_exp2.sv @@
// exponent stages: z = 2^(-x*log2e) with an 8-bit mantissa
module swgl_exp2 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  swgl_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output swgl_pkg::exp_item_t out_item
);
    import swgl_pkg::*;

    localparam int NSTG = POW_STEPS + 3;

    typedef struct packed {
        logic signed [31:0] gate_value;
        logic signed [31:0] up_value;
        logic [15:0]        frac;
        logic signed [16:0] expo;
        logic [30:0]        acc;
    } pw_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] feed;
    logic [NSTG:0]   go;

    always_comb begin
        go[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            go[k] = !vld_reg[k] || go[k+1];
        end
    end

    assign feed = {vld_reg[NSTG-2:0], in_valid};

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            vld_next[k] = go[k] ? feed[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage a: x * log2e
    logic signed [31:0] xa_reg;
    logic signed [31:0] ua_reg;
    logic signed [62:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            xa_reg   <= in_item.gate_value;
            ua_reg   <= in_item.up_value;
            prod_reg <= in_item.gate_value * LOG2E_Q30;
        end
    end

    // stage b: t = round(-p / 2^30), split into exponent and fraction
    logic signed [63:0] negp;
    pw_t                pb_reg;

    assign negp = 64'sh2000_0000 - {prod_reg[62], prod_reg};

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            pb_reg.gate_value <= xa_reg;
            pb_reg.up_value   <= ua_reg;
            pb_reg.frac       <= negp[45:30];
            pb_reg.expo       <= negp[62:46];
            pb_reg.acc        <= 31'h4000_0000;
        end
    end

    // one multiply per stage for each fraction bit
    pw_t         pw_reg [POW_STEPS];
    pw_t         pw_in  [POW_STEPS];
    pw_t         pw_out [POW_STEPS];
    logic [47:0] mult   [POW_STEPS];

    always_comb begin
        pw_in[0] = pb_reg;
        for (int k = 1; k < POW_STEPS; k++) begin
            pw_in[k] = pw_reg[k-1];
        end
        for (int k = 0; k < POW_STEPS; k++) begin
            mult[k]   = 48'(pw_in[k].acc) * 48'(POW2_TAB[k]) + 48'd16384;
            pw_out[k] = pw_in[k];
            if (pw_in[k].frac[POW_STEPS-1-k]) begin
                pw_out[k].acc = mult[k][45:15];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < POW_STEPS; k++) begin
            if (go[k+2]) begin
                pw_reg[k] <= pw_out[k];
            end
        end
    end

    // mantissa rounding with carry into the exponent, range flags
    logic [31:0]        msum;
    logic [7:0]         mant;
    logic signed [16:0] eadj;
    logic signed [16:0] ebias;
    exp_item_t          om_reg;

    always_comb begin
        msum = 32'(pw_reg[POW_STEPS-1].acc) + 32'h0040_0000;
        if (msum[31]) begin
            mant = 8'd128;
            eadj = pw_reg[POW_STEPS-1].expo + 17'sd1;
        end else begin
            mant = msum[30:23];
            eadj = pw_reg[POW_STEPS-1].expo;
        end
        ebias = eadj + 17'sd24;
    end

    always_ff @(posedge aclk) begin
        if (go[NSTG-1]) begin
            om_reg.gate_value <= pw_reg[POW_STEPS-1].gate_value;
            om_reg.up_value   <= pw_reg[POW_STEPS-1].up_value;
            om_reg.mant       <= mant;
            om_reg.shamt      <= ebias[5:0];
            om_reg.zero       <= (eadj >= 17'sd17);
            om_reg.full       <= (eadj <= -17'sd25);
        end
    end

    assign out_item = om_reg;

endmodule

@@ src/swgl_recip.sv @@
// sigmoid stages: 1/(1+z) by table seed and one newton step
module swgl_recip (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  swgl_pkg::exp_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output swgl_pkg::sig_item_t out_item
);
    import swgl_pkg::*;

    localparam int NSTG = 6;

    typedef struct packed {
        logic signed [31:0] gate_value;
        logic signed [31:0] up_value;
        logic               zero;
        logic               full;
        logic [4:0]         sh;
    } ctl_t;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] feed;
    logic [NSTG:0]   go;

    always_comb begin
        go[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            go[k] = !vld_reg[k] || go[k+1];
        end
    end

    assign feed = {vld_reg[NSTG-2:0], in_valid};

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            vld_next[k] = go[k] ? feed[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[NSTG-1];

    ctl_t ctl_reg [NSTG-1];
    ctl_t ctl_in  [NSTG-1];

    logic [48:0] dq_reg;
    logic [30:0] dn_reg;
    logic [30:0] dn3_reg;
    logic [29:0] rs_reg;
    logic [29:0] rs4_reg;
    logic [31:0] prod_reg;
    logic [31:0] rf_reg;
    sig_item_t   os_reg;

    // leading one of d and normalization to [1,2)
    logic [5:0]  lead;
    logic [5:0]  norm;
    logic [4:0]  sh;
    logic [48:0] dshift;

    always_comb begin
        lead = 6'd31;
        for (int k = 32; k <= 48; k++) begin
            if (dq_reg[k]) begin
                lead = 6'(k);
            end
        end
        norm   = lead - 6'd30;
        sh     = 5'(lead - 6'd17);
        dshift = dq_reg >> norm;
    end

    always_comb begin
        ctl_in[0].gate_value = in_item.gate_value;
        ctl_in[0].up_value   = in_item.up_value;
        ctl_in[0].zero       = in_item.zero;
        ctl_in[0].full       = in_item.full;
        ctl_in[0].sh         = '0;
        ctl_in[1]            = ctl_reg[0];
        ctl_in[1].sh         = sh;
        for (int k = 2; k < NSTG - 1; k++) begin
            ctl_in[k] = ctl_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG - 1; k++) begin
            if (go[k]) begin
                ctl_reg[k] <= ctl_in[k];
            end
        end
    end

    // newton step products
    logic [60:0] p1;
    logic [31:0] diff;
    logic [61:0] p2;
    logic [32:0] rsum;
    logic [32:0] rf2;
    logic [15:0] sig;

    always_comb begin
        p1   = 61'(dn3_reg) * 61'(rs_reg);
        diff = 32'h8000_0000 - prod_reg;
        p2   = 62'(rs4_reg) * 62'(diff);
        rsum = 33'(rf_reg) + (33'd1 << (ctl_reg[4].sh - 5'd1));
        rf2  = rsum >> ctl_reg[4].sh;
        if (ctl_reg[4].zero) begin
            sig = '0;
        end else if (ctl_reg[4].full || rf2 > 33'(SIG_MAX)) begin
            sig = SIG_MAX;
        end else begin
            sig = rf2[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            dq_reg <= (49'd1 << 31) + (49'(in_item.mant) << in_item.shamt);
        end
        if (go[1]) begin
            dn_reg <= dshift[30:0];
        end
        if (go[2]) begin
            dn3_reg <= dn_reg;
            rs_reg  <= SEED_TAB[dn_reg[29:22]];
        end
        if (go[3]) begin
            prod_reg <= 32'(p1[60:30]);
            rs4_reg  <= rs_reg;
        end
        if (go[4]) begin
            rf_reg <= prod_reg[31] ? 32'd0 : p2[61:30];
        end
        if (go[5]) begin
            os_reg.gate_value <= ctl_reg[4].gate_value;
            os_reg.up_value   <= ctl_reg[4].up_value;
            os_reg.sig        <= sig;
        end
    end

    assign out_item = os_reg;

endmodule

@@ src/swgl_gate.sv @@
// product stages: x * sigmoid * u with rounding and saturation
module swgl_gate (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  swgl_pkg::sig_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output swgl_pkg::out_item_t out_item
);
    import swgl_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] feed;
    logic [NSTG:0]   go;

    always_comb begin
        go[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            go[k] = !vld_reg[k] || go[k+1];
        end
    end

    assign feed = {vld_reg[NSTG-2:0], in_valid};

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            vld_next[k] = go[k] ? feed[k] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[NSTG-1];

    logic signed [48:0] pg_reg;
    logic signed [31:0] u1_reg;
    logic signed [31:0] g_reg;
    logic signed [31:0] u2_reg;
    logic signed [63:0] pr_reg;
    out_item_t          o_reg;

    logic signed [48:0] pg_rnd;
    logic signed [63:0] pr_rnd;
    logic               pos_ovf;
    logic               neg_ovf;

    always_comb begin
        pg_rnd  = pg_reg + 49'sd32768;
        pr_rnd  = pr_reg + 64'sd32768;
        // rounded result lives in bits 63:16, must fit in 32 signed bits
        pos_ovf = !pr_rnd[63] && (pr_rnd[62:47] != '0);
        neg_ovf = pr_rnd[63] && (pr_rnd[62:47] != '1);
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            pg_reg <= in_item.gate_value * $signed({1'b0, in_item.sig});
            u1_reg <= in_item.up_value;
        end
        if (go[1]) begin
            g_reg  <= pg_rnd[47:16];
            u2_reg <= u1_reg;
        end
        if (go[2]) begin
            pr_reg <= g_reg * u2_reg;
        end
        if (go[3]) begin
            if (pos_ovf) begin
                o_reg.result_value <= 32'sh7FFF_FFFF;
                o_reg.saturated    <= 1'b1;
            end else if (neg_ovf) begin
                o_reg.result_value <= 32'sh8000_0000;
                o_reg.saturated    <= 1'b1;
            end else begin
                o_reg.result_value <= pr_rnd[47:16];
                o_reg.saturated    <= 1'b0;
            end
        end
    end

    assign out_item = o_reg;

endmodule

@@ src/swiglu_activation.sv @@
// top level of the swiglu activation unit
//
// Streaming elementwise swiglu: each request on the s_ channel carries a
// gate value x and an up value u (signed q16.16); each request on the m_
// channel carries x*sigmoid(x)*u in signed q16.16 plus a saturated flag.
// Both channels use valid/ready; a request moves when both are high.
//
// From an accepted input to its result at m_valid the pipeline has
// 19 exponent stages (one multiply for each of the 16 fraction bits of the
// exp2 product chain), 6 reciprocal and newton stages, 4 product stages.
// Throughput is one item per cycle while m_ready is high; the per-bit exp2
// multiplier chain sets the depth, every stage holds one multiply at most.
//
// Reset (aresetn low, synchronous) empties the pipeline; items in flight
// are dropped. When m_ready is low, no item is lost or created: the full
// stages hold their items and bubbles ahead of them keep filling, so
// s_ready stays high until the pipeline is completely full.
module swiglu_activation (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swgl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swgl_pkg::out_item_t m_data
);
    import swgl_pkg::*;

    logic      e_valid;
    logic      e_ready;
    exp_item_t e_item;
    logic      r_valid;
    logic      r_ready;
    sig_item_t r_item;

    swgl_exp2 u_exp2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .out_item  (e_item)
    );

    swgl_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .in_item   (e_item),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_item  (r_item)
    );

    swgl_gate u_gate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_item   (r_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule
